FILE: rtl/aslc_pkg.sv
`timescale 1ns / 1ps

package aslc_pkg;

	// Operation codes carried by the operation field
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Register indexes of the configuration port
	localparam int unsigned REG_DEVICE_ADDRESS = 0;

	localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h14;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	// Bit 6 of command byte 1 is the beacon enable, not a steady lamp
	localparam int unsigned BEACON_BIT = 6;
	localparam logic [7:0] STEADY_MASK = 8'hBF;

	// Blink phases within one period
	localparam int unsigned BOTTOM_ON_PHASE = 1;
	localparam int unsigned BOTTOM_OFF_PHASE = 3;
	localparam int unsigned TOP_ON_PHASE = 45;
	localparam int unsigned TOP_OFF_PHASE = 47;
	localparam int unsigned STROBE_ON_COUNT = 1;
	localparam int unsigned STROBE_OFF_COUNT = 2;

	// Latch command from a completed addressed frame
	typedef struct packed {
		logic       latch;
		logic [7:0] lights;
		logic       beacon_en;
		logic       strobe_en;
	} lamp_cmd_t;

	// Lamp drive pins
	typedef struct packed {
		logic strobe;
		logic top;
		logic bottom;
	} lamp_pins_t;

endpackage

FILE: rtl/aslc_frame.sv
`timescale 1ns / 1ps

module aslc_frame #(
	parameter int unsigned FRAME_BYTES = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_en,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          device_address,
	output aslc_pkg::lamp_cmd_t cmd
);

	localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(FRAME_BYTES);
	localparam logic [CNT_W-1:0] MIN_COUNT = CNT_W'(3);

	logic [CNT_W-1:0] count_q;
	logic             ignored_q;
	logic             saw_lf_q;
	// Only bytes 0 to 2 of a frame are ever read back; later bytes are not kept
	logic [7:0]       byte0_q;
	logic [7:0]       byte1_q;
	logic [7:0]       byte2_q;

	logic [CNT_W-1:0] cnt0;
	logic [CNT_W-1:0] cnt1;
	logic [CNT_W-1:0] count_n;
	logic             ign0;
	logic             ignored_n;
	logic             lf0;
	logic             saw_lf_n;
	logic             is_cr;
	logic             is_lf;
	logic             ready;
	logic [7:0]       b0_e;
	logic [7:0]       b1_e;
	logic [7:0]       b2_e;

	always_comb begin
		is_cr = (rx_byte == aslc_pkg::CHAR_CR);
		is_lf = (rx_byte == aslc_pkg::CHAR_LF);

		// A byte on a full frame starts a fresh one
		if (count_q >= FULL_COUNT) begin
			cnt0 = '0;
			ign0 = 1'b1;
			lf0  = 1'b0;
		end else begin
			cnt0 = count_q;
			ign0 = ignored_q;
			lf0  = saw_lf_q;
		end
		if (cnt0 == '0 && rx_byte == device_address) begin
			ign0 = 1'b0;
		end
		cnt1 = cnt0 + CNT_W'(1);

		b0_e = (cnt0 == CNT_W'(0)) ? rx_byte : byte0_q;
		b1_e = (cnt0 == CNT_W'(1)) ? rx_byte : byte1_q;
		b2_e = (cnt0 == CNT_W'(2)) ? rx_byte : byte2_q;

		ready     = is_cr && lf0 && !ign0;
		count_n   = cnt1;
		ignored_n = ign0;
		if (is_cr && lf0) begin
			count_n   = '0;
			ignored_n = 1'b1;
		end
		saw_lf_n = is_lf ? 1'b1 : (is_cr ? lf0 : 1'b0);

		cmd.latch     = ready && (b0_e == device_address) && (cnt1 >= MIN_COUNT);
		cmd.lights    = b1_e & aslc_pkg::STEADY_MASK;
		cmd.beacon_en = b1_e[aslc_pkg::BEACON_BIT];
		cmd.strobe_en = b2_e[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ignored_q <= 1'b1;
			saw_lf_q  <= 1'b0;
		end else if (byte_en) begin
			count_q   <= count_n;
			ignored_q <= ignored_n;
			saw_lf_q  <= saw_lf_n;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_en) begin
			if (cnt0 == CNT_W'(0)) byte0_q <= rx_byte;
			if (cnt0 == CNT_W'(1)) byte1_q <= rx_byte;
			if (cnt0 == CNT_W'(2)) byte2_q <= rx_byte;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("frame count beyond frame size");

	a_latch_on_byte: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |-> (byte_en || !byte_en) && is_cr && !ign0)
		else $error("latch without CR on an addressed frame");

	a_end_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_en && is_cr && lf0) |=> (count_q == '0 && ignored_q))
		else $error("frame not emptied after end");

endmodule

FILE: rtl/aslc_lamps.sv
`timescale 1ns / 1ps

module aslc_lamps #(
	parameter int unsigned BLINK_PERIOD = 90
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick_en,
	input  logic                 byte_en,
	input  aslc_pkg::lamp_cmd_t  cmd,
	output logic [7:0]           lights,
	output aslc_pkg::lamp_pins_t pins
);

	localparam int unsigned PH_W = $clog2(BLINK_PERIOD);
	localparam logic [PH_W-1:0] LAST_PHASE = PH_W'(BLINK_PERIOD - 1);
	localparam logic [PH_W-1:0] BOT_ON = PH_W'(aslc_pkg::BOTTOM_ON_PHASE);
	localparam logic [PH_W-1:0] BOT_OFF = PH_W'(aslc_pkg::BOTTOM_OFF_PHASE);
	localparam logic [PH_W-1:0] TOP_ON = PH_W'(aslc_pkg::TOP_ON_PHASE);
	localparam logic [PH_W-1:0] TOP_OFF = PH_W'(aslc_pkg::TOP_OFF_PHASE);
	localparam logic [PH_W-1:0] STB_ON = PH_W'(aslc_pkg::STROBE_ON_COUNT);
	localparam logic [PH_W-1:0] STB_OFF = PH_W'(aslc_pkg::STROBE_OFF_COUNT);

	logic [7:0]           lights_q;
	logic                 top_en_q;
	logic                 bottom_en_q;
	logic                 strobe_en_q;
	logic [PH_W-1:0]      strobe_phase_q;
	logic [PH_W-1:0]      tick_phase_q;
	aslc_pkg::lamp_pins_t pins_q;

	logic [PH_W-1:0]      strobe_phase_n;
	aslc_pkg::lamp_pins_t tick_pins;

	always_comb begin
		tick_pins = pins_q;
		if (tick_phase_q == BOT_ON && bottom_en_q) tick_pins.bottom = 1'b1;
		if (tick_phase_q == BOT_OFF) tick_pins.bottom = 1'b0;
		if (tick_phase_q == TOP_ON && top_en_q) tick_pins.top = 1'b1;
		if (tick_phase_q == TOP_OFF) tick_pins.top = 1'b0;

		strobe_phase_n = strobe_phase_q;
		if (strobe_en_q) begin
			strobe_phase_n = (strobe_phase_q == LAST_PHASE) ? '0 : strobe_phase_q + PH_W'(1);
			if (strobe_phase_n == STB_ON) tick_pins.strobe = 1'b1;
		end
		if (strobe_phase_n == STB_OFF) tick_pins.strobe = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lights_q       <= '0;
			top_en_q       <= 1'b1;
			bottom_en_q    <= 1'b1;
			strobe_en_q    <= 1'b0;
			strobe_phase_q <= '0;
			tick_phase_q   <= '0;
			pins_q         <= '0;
		end else if (tick_en) begin
			pins_q         <= tick_pins;
			strobe_phase_q <= strobe_phase_n;
			tick_phase_q   <= (tick_phase_q == LAST_PHASE) ? '0 : tick_phase_q + PH_W'(1);
		end else if (byte_en && cmd.latch) begin
			lights_q    <= cmd.lights;
			top_en_q    <= cmd.beacon_en;
			bottom_en_q <= cmd.beacon_en;
			strobe_en_q <= cmd.strobe_en;
			if (!cmd.strobe_en) begin
				strobe_phase_q <= '0;
				pins_q.strobe  <= 1'b0;
			end
		end
	end

	assign lights = lights_q;
	assign pins   = pins_q;

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_phase_q <= LAST_PHASE && strobe_phase_q <= LAST_PHASE)
		else $error("blink phase out of range");

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!strobe_en_q |-> strobe_phase_q == '0)
		else $error("strobe count runs while disabled");

	a_beacons_paired: assert property (@(posedge clk) disable iff (!arst_n)
		top_en_q == bottom_en_q)
		else $error("beacon enables differ");

endmodule

FILE: rtl/addressed_serial_light_controller.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// ------    ---------  -------------------  ---------------------------------------------
// input     in         in_valid / in_stall  operation, rx_byte
// result    out        out_valid/out_stall  steady_lights, beacon_top_lamp,
//                                           beacon_bottom_lamp, strobe_lamp, command_done
// config    in         APB psel/penable     paddr, pwdata, prdata, pready (always high)
//
// One input transaction per cycle while the result is not stalled; each input is taken into
// the input register, then lamp state and command_done register its result on advance.
// Reset (arst_n low) clears frame state, lamp state, blink phases and both valid flags;
// device_address returns to 0x14.
// A stalled result holds the lamp state and freezes the input register; in_stall then
// rises only while the input register is occupied.

module addressed_serial_light_controller #(
	parameter int unsigned FRAME_BYTES  = 12,
	parameter int unsigned BLINK_PERIOD = 90
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  rx_byte,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  steady_lights,
	output logic        beacon_top_lamp,
	output logic        beacon_bottom_lamp,
	output logic        strobe_lamp,
	output logic        command_done
);

	// Configuration register
	logic [7:0] device_address_q;
	logic       reg_sel;

	// Word index of the access: paddr[2] selects the register, low bits are byte offsets
	assign reg_sel = (paddr[2] == 1'(aslc_pkg::REG_DEVICE_ADDRESS));
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {24'd0, device_address_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= aslc_pkg::DEVICE_ADDRESS_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			device_address_q <= pwdata[7:0];
		end
	end

	// Input register
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic       done_q;
	logic       out_free;
	logic       advance;
	logic       tick_en;
	logic       byte_en;

	// The result slot is free when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign tick_en  = advance && (op_s1 == aslc_pkg::OP_TICK);
	assign byte_en  = advance && (op_s1 == aslc_pkg::OP_BYTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold payload while stalled
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= operation;
			byte_s1 <= rx_byte;
		end
	end

	// Frame assembly and lamp state
	aslc_pkg::lamp_cmd_t  cmd;
	aslc_pkg::lamp_pins_t pins;
	logic [7:0]           lights;

	aslc_frame #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_en       (byte_en),
		.rx_byte       (byte_s1),
		.device_address(device_address_q),
		.cmd           (cmd)
	);

	aslc_lamps #(
		.BLINK_PERIOD(BLINK_PERIOD)
	) u_lamps (
		.clk    (clk),
		.arst_n (arst_n),
		.tick_en(tick_en),
		.byte_en(byte_en),
		.cmd    (cmd),
		.lights (lights),
		.pins   (pins)
	);

	// Result register: lamp state only moves on advance, so it doubles as the result payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			done_q <= byte_en && cmd.latch;
		end
	end

	assign out_valid          = out_valid_q;
	assign steady_lights      = lights;
	assign beacon_top_lamp    = pins.top;
	assign beacon_bottom_lamp = pins.bottom;
	assign strobe_lamp        = pins.strobe;
	assign command_done       = done_q;

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && out_stall) |=> valid_s1)
		else $error("input register dropped a transaction under stall");

	a_lights_bit6: assert property (@(posedge clk) disable iff (!arst_n)
		!steady_lights[aslc_pkg::BEACON_BIT])
		else $error("beacon bit leaked into steady lights");

	a_done_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (command_done |-> $past(op_s1) == aslc_pkg::OP_BYTE))
		else $error("command done on a tick");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int unsigned N_FRAME  = 12;
	localparam int unsigned N_PERIOD = 90;

	// One input transaction as offered to the block
	typedef struct {
		logic       op;
		logic [7:0] data;
	} light_item_t;

	// One result transaction as expected from the block
	typedef struct {
		logic [7:0] lights;
		logic       top;
		logic       bottom;
		logic       strobe;
		logic       done;
	} lamp_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = aslc_pkg::OP_BYTE;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  steady_lights;
	logic        beacon_top_lamp;
	logic        beacon_bottom_lamp;
	logic        strobe_lamp;
	logic        command_done;

	addressed_serial_light_controller #(
		.FRAME_BYTES (N_FRAME),
		.BLINK_PERIOD(N_PERIOD)
	) dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.operation         (operation),
		.rx_byte           (rx_byte),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.steady_lights     (steady_lights),
		.beacon_top_lamp   (beacon_top_lamp),
		.beacon_bottom_lamp(beacon_bottom_lamp),
		.strobe_lamp       (strobe_lamp),
		.command_done      (command_done)
	);

	// Mirror of the controller state, reset values as after arst_n
	logic [7:0]           frm_buf [N_FRAME];
	int unsigned          frm_len = 0;
	bit                   frm_skip = 1'b1;
	bit                   lf_seen = 1'b0;
	logic [7:0]           lamp_bits = '0;
	bit                   top_en = 1'b1;
	bit                   bot_en = 1'b1;
	bit                   strobe_en = 1'b0;
	int unsigned          strobe_cnt = 0;
	int unsigned          blink_cnt = 0;
	aslc_pkg::lamp_pins_t pins = '0;
	logic [7:0]           addr_copy = aslc_pkg::DEVICE_ADDRESS_RESET;

	light_item_t  light_items [$];
	lamp_result_t lamp_results_due [$];
	int unsigned  queued_items = 0;
	int unsigned  results_seen = 0;
	int unsigned  errors = 0;
	bit           gappy = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Gap length: mostly none or short, now and then long
	function automatic int unsigned rand_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!gappy || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Advance the mirrored state by one accepted input transaction and queue the
	// lamp state the block must report for it
	task automatic compute_lamp_state(input logic op, input logic [7:0] data);
		lamp_result_t res;
		bit ready;
		bit done;
		ready = 1'b0;
		done = 1'b0;
		if (op == aslc_pkg::OP_BYTE) begin
			// A byte landing on a full frame restarts the frame
			if (frm_len >= N_FRAME) begin
				lf_seen = 1'b0;
				frm_len = 0;
				frm_skip = 1'b1;
			end
			if (frm_len == 0 && data == addr_copy)
				frm_skip = 1'b0;
			frm_buf[frm_len] = data;
			frm_len++;
			if (data == aslc_pkg::CHAR_CR) begin
				if (lf_seen) begin
					if (!frm_skip) begin
						ready = 1'b1;
					end else begin
						// Unaddressed end: drop the frame, keep the LF
						frm_len = 0;
						frm_skip = 1'b1;
					end
				end
			end else begin
				lf_seen = 1'b0;
			end
			if (data == aslc_pkg::CHAR_LF)
				lf_seen = 1'b1;
			if (ready) begin
				if (frm_buf[0] == addr_copy && frm_len >= 3) begin
					lamp_bits = frm_buf[1] & aslc_pkg::STEADY_MASK;
					top_en = frm_buf[1][aslc_pkg::BEACON_BIT];
					bot_en = top_en;
					if (frm_buf[2][0]) begin
						strobe_en = 1'b1;
					end else begin
						// Strobe off takes effect at once
						strobe_en = 1'b0;
						strobe_cnt = 0;
						pins.strobe = 1'b0;
					end
					done = 1'b1;
				end
				frm_len = 0;
				frm_skip = 1'b1;
			end
		end else begin
			if (blink_cnt == aslc_pkg::BOTTOM_ON_PHASE && bot_en)
				pins.bottom = 1'b1;
			if (blink_cnt == aslc_pkg::BOTTOM_OFF_PHASE)
				pins.bottom = 1'b0;
			if (blink_cnt == aslc_pkg::TOP_ON_PHASE && top_en)
				pins.top = 1'b1;
			if (blink_cnt == aslc_pkg::TOP_OFF_PHASE)
				pins.top = 1'b0;
			if (strobe_en) begin
				strobe_cnt++;
				if (strobe_cnt >= N_PERIOD)
					strobe_cnt = 0;
				if (strobe_cnt == aslc_pkg::STROBE_ON_COUNT)
					pins.strobe = 1'b1;
			end
			// A stale count still turns the strobe off while disabled
			if (strobe_cnt == aslc_pkg::STROBE_OFF_COUNT)
				pins.strobe = 1'b0;
			blink_cnt++;
			if (blink_cnt >= N_PERIOD)
				blink_cnt = 0;
		end
		res.lights = lamp_bits & aslc_pkg::STEADY_MASK;
		res.top = pins.top;
		res.bottom = pins.bottom;
		res.strobe = pins.strobe;
		res.done = done;
		lamp_results_due.push_back(res);
	endtask

	// Driver: hold a stalled transaction, advance the mirror on acceptance, then
	// offer the next pending item once its gap has run out
	always @(posedge clk) begin : drive_inputs
		light_item_t nxt;
		int unsigned gap_left;
		bit          busy;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			busy = in_valid;
			if (in_valid && !in_stall) begin
				compute_lamp_state(operation, rx_byte);
				busy = 1'b0;
			end
			if (!busy) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (light_items.size() > 0) begin
					nxt = light_items.pop_front();
					in_valid <= 1'b1;
					operation <= nxt.op;
					rx_byte <= nxt.data;
					gap_left = rand_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver back-pressure: random stalls, plus one long hold-off once a few
	// hundred results have come so the block fills and stalls its input
	always @(posedge clk) begin : drive_stall
		int unsigned stall_left;
		int unsigned hold_left;
		bit          long_done;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			hold_left = 0;
			long_done = 1'b0;
		end else begin
			if (!long_done && results_seen >= 300) begin
				long_done = 1'b1;
				hold_left = 250;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0)
					stall_left = rand_gap();
			end
		end
	end

	task automatic check_field(input string what, input int unsigned want,
				   input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, what, want, got);
		end
	endtask

	// Monitor: compare each accepted result transaction with the oldest expectation
	always @(posedge clk) begin : watch_results
		lamp_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (lamp_results_due.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, lights %0h done %0b",
					 $time, steady_lights, command_done);
			end else begin
				want = lamp_results_due.pop_front();
				check_field("steady_lights", want.lights, steady_lights);
				check_field("beacon_top_lamp", want.top, beacon_top_lamp);
				check_field("beacon_bottom_lamp", want.bottom, beacon_bottom_lamp);
				check_field("strobe_lamp", want.strobe, strobe_lamp);
				check_field("command_done", want.done, command_done);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		light_item_t it;
		it.op = aslc_pkg::OP_BYTE;
		it.data = b;
		light_items.push_back(it);
		queued_items++;
	endtask

	task automatic send_ticks(input int unsigned n);
		light_item_t it;
		repeat (n) begin
			it.op = aslc_pkg::OP_TICK;
			it.data = 8'($urandom);
			light_items.push_back(it);
			queued_items++;
		end
	endtask

	// Well-formed frame: first byte, two command bytes, filler, then LF CR
	task automatic send_frame(input logic [7:0] first, input logic [7:0] b1,
				  input logic [7:0] b2, input int unsigned extra);
		send_byte(first);
		send_byte(b1);
		send_byte(b2);
		repeat (extra)
			send_byte(8'($urandom));
		send_byte(aslc_pkg::CHAR_LF);
		send_byte(aslc_pkg::CHAR_CR);
	endtask

	// Mostly well-formed frames with random content between runs of ticks;
	// the rest is broken frames, overflows and noise
	task automatic random_traffic(input int unsigned n);
		int unsigned stop_at;
		int unsigned r;
		logic [7:0]  first;
		stop_at = queued_items + n;
		while (queued_items < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				first = ($urandom_range(0, 9) < 8) ? addr_copy : 8'($urandom);
				send_frame(first, 8'($urandom), 8'($urandom), $urandom_range(0, 7));
			end else if (r < 80) begin
				send_ticks($urandom_range(1, 40));
			end else if (r < 88) begin
				// Broken frame: LF not followed by CR, or a short frame with a doubled LF before the CR
				send_byte(addr_copy);
				send_byte(8'($urandom));
				send_byte(aslc_pkg::CHAR_LF);
				send_byte(($urandom_range(0, 1) == 0) ? 8'($urandom) : aslc_pkg::CHAR_LF);
				send_byte(aslc_pkg::CHAR_CR);
			end else if (r < 94) begin
				// Overflow run, ending with LF CR as a frame would
				send_byte(addr_copy);
				repeat ($urandom_range(12, 18))
					send_byte(8'($urandom));
				send_byte(aslc_pkg::CHAR_LF);
				send_byte(aslc_pkg::CHAR_CR);
			end else begin
				repeat ($urandom_range(1, 5)) begin
					case ($urandom_range(0, 2))
						0: send_byte(aslc_pkg::CHAR_LF);
						1: send_byte(aslc_pkg::CHAR_CR);
						default: send_byte(8'($urandom));
					endcase
				end
			end
		end
	endtask

	// Wait until every item is accepted and every result has come, then settle
	task automatic wait_drained();
		do
			@(negedge clk);
		while (light_items.size() != 0 || in_valid || lamp_results_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Write the device address, then read it back
	task automatic set_address(input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(aslc_pkg::REG_DEVICE_ADDRESS * 4);
		pwdata <= {24'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		addr_copy = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		check_field("device_address readback", value, prdata[7:0]);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin : stimulus
		logic [7:0] addr_set [6];
		addr_set[0] = aslc_pkg::DEVICE_ADDRESS_RESET;
		addr_set[1] = 8'h00;
		addr_set[2] = 8'hFF;
		addr_set[3] = aslc_pkg::CHAR_CR;
		addr_set[4] = aslc_pkg::CHAR_LF;
		addr_set[5] = 8'($urandom);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int p = 0; p < 6; p++) begin
			set_address(addr_set[p]);
			gappy = (p % 3 != 1);
			if (p == 0) begin
				// Directed: all lamps and strobe on, then ticks past the bottom
				// beacon's on phase
				send_frame(addr_copy, 8'hFF, 8'h01, 0);
				send_ticks(4);
				// Beacons and strobe off: the strobe goes dark at once, lit beacons stay until their off phase
				send_frame(addr_copy, 8'h00, 8'h00, 0);
				// Unaddressed frame ending twice on a trailing CR
				send_byte(8'h33);
				send_byte(aslc_pkg::CHAR_LF);
				send_byte(aslc_pkg::CHAR_CR);
				send_byte(aslc_pkg::CHAR_CR);
				// Overflow of a frame that started addressed
				send_byte(addr_copy);
				repeat (12)
					send_byte(8'hAA);
				send_byte(aslc_pkg::CHAR_LF);
				send_byte(aslc_pkg::CHAR_CR);
			end
			random_traffic(265);
			wait_drained();
		end

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
